### hdl/assert_macros.svh
// Assertion macros shared by the allocator's checking code
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

### hdl/nfbt_pkg.sv
// Package: arena geometry, header word, sequencer codes and inter-module structs
`timescale 1ns / 1ps
package nfbt_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 32;
  localparam int GRAN_COUNT   = ARENA_BYTES / ALIGN_BYTES;
  localparam int HDR_G        = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int GRAN_W       = $clog2(GRAN_COUNT);
  localparam int ALIGN_SH     = $clog2(ALIGN_BYTES);

  // request codes
  localparam logic [1:0] REQ_REALLOC = 2'd0;
  localparam logic [1:0] REQ_REINIT  = 2'd1;
  localparam logic [1:0] REQ_CLOSE   = 2'd2;

  // one header entry per granule, start mark kept in the same word
  typedef struct packed {
    logic              mark;
    logic              free;
    logic [GRAN_W-1:0] size;
    logic [GRAN_W-1:0] prev;
  } hdr_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH,
    ST_FND_RD, ST_FND_CHK,
    ST_MN_RD, ST_MN_CHK, ST_MP, ST_MP_CHK, ST_MG_WR,
    ST_PB_RD, ST_PB_CHK,
    ST_AL_INIT, ST_AL_RD, ST_AL_CHK, ST_SP_WR, ST_AL_WRG,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_ALLOC, MODE_REALLOC, MODE_FREE
  } mode_t;

  typedef struct packed {
    logic              we;
    logic [GRAN_W-1:0] waddr;
    hdr_word_t         wdata;
    logic [GRAN_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [GRAN_W-1:0] base;
    logic [GRAN_W:0]   len;
  } step_req_t;

  typedef struct packed {
    logic [GRAN_W+1:0] sum;
    logic              in_range;
  } step_rsp_t;

  typedef struct packed {
    logic clearing;
    logic scanning;
  } status_t;

endpackage

### hdl/nfbt_req_if.sv
// Request channel interface
`timescale 1ns / 1ps
interface nfbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        pointer_present;
  logic [15:0] pointer_offset;
  logic [15:0] request_size;

  modport source (output valid, req_type, pointer_present, pointer_offset, request_size,
                  input ready);
  modport sink   (input valid, req_type, pointer_present, pointer_offset, request_size,
                  output ready);
endinterface

### hdl/nfbt_rsp_if.sv
// Result channel interface
`timescale 1ns / 1ps
interface nfbt_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_present;
  logic [15:0] result_offset;
  logic        moved;
  logic [15:0] copy_source;
  logic [15:0] copy_length;
  logic [16:0] used_bytes;
  logic [16:0] peak_used;

  modport source (output valid, result_present, result_offset, moved, copy_source,
                  copy_length, used_bytes, peak_used, input ready);
  modport sink   (input valid, result_present, result_offset, moved, copy_source,
                  copy_length, used_bytes, peak_used, output ready);
endinterface

### hdl/next_fit_boundary_tag_allocator_unit.sv
// Next-fit allocator with boundary-tag coalescing: top level
// Channels: in_req carries one realloc-style, reinitialize or close request; out_rsp
// returns one result per request (payload offset, move source and length, usage).
// A transaction happens on a rising clk edge with valid and ready both high.
// One request at a time: in_req.ready is high only while idle, and a new request
// is taken once the previous result has been collected.
// Every header access is a registered read of the header store. Close, unknown codes
// and requests on a closed arena go from decode straight to the result; a free reads
// the block header, tries both merges and may publish the merged size to the next
// header; an allocation walks block headers from the rover, then may split, publish
// and write the chosen header; a relocating grow adds the header lookup and the
// freeing of the old block.
// Reset (rst_n low, synchronous) and reinitialize start a clearing pass over the
// header store, one entry a cycle, during which no request is taken; a
// reinitialize delivers its result once the pass has ended.
// A stalled receiver simply holds the result in the output registers; the block
// waits and takes no new request until out_rsp.ready is seen.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module next_fit_boundary_tag_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  nfbt_req_if.sink    in_req,
  nfbt_rsp_if.source  out_rsp
);

  nfbt_pkg::ram_req_t  ram_req;
  nfbt_pkg::hdr_word_t ram_rdata;
  nfbt_pkg::step_req_t step_req;
  nfbt_pkg::step_rsp_t step_rsp;
  nfbt_pkg::status_t   status;

  // sequencer and datapath
  nfbt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (in_req),
    .rsp      (out_rsp),
    .ram_req  (ram_req),
    .rd       (ram_rdata),
    .step_req (step_req),
    .step_rsp (step_rsp),
    .status   (status)
  );

  // header store
  nfbt_hdr_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // shared block-step adder
  nfbt_step_unit u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  // checks
  `ASSERT_IMPL(a_one_at_a_time, out_rsp.valid, !in_req.ready)
  `ASSERT_IMPL(a_clear_blocks, status.clearing, !in_req.ready && !out_rsp.valid)
  `ASSERT_IMPL(a_scan_no_result, status.scanning, !out_rsp.valid && !in_req.ready)
  `ASSERT_NEXT(a_no_instant_result, in_req.valid && in_req.ready, !out_rsp.valid)
  `ASSERT_IMPL(a_peak_bound, out_rsp.valid, out_rsp.used_bytes <= out_rsp.peak_used)

endmodule

### hdl/nfbt_hdr_ram.sv
// Header store: one word per granule, one write and one registered read per cycle
`timescale 1ns / 1ps
module nfbt_hdr_ram (
  input  logic                 clk,
  input  nfbt_pkg::ram_req_t   req,
  output nfbt_pkg::hdr_word_t  rdata
);

  nfbt_pkg::hdr_word_t mem [nfbt_pkg::GRAN_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

### hdl/nfbt_step_unit.sv
// Shared block-step adder: base granule plus header plus payload length
`timescale 1ns / 1ps
module nfbt_step_unit (
  input  nfbt_pkg::step_req_t req,
  output nfbt_pkg::step_rsp_t rsp
);

  localparam int SW = nfbt_pkg::GRAN_W + 2;

  logic [SW-1:0] sum;

  assign sum = SW'(req.base) + SW'(nfbt_pkg::HDR_G) + SW'(req.len);
  assign rsp.sum = sum;
  assign rsp.in_range = (sum < SW'(nfbt_pkg::GRAN_COUNT));

endmodule

### hdl/nfbt_seq.sv
// Sequencer and datapath: decode, free/merge, next-fit scan, split and publish
`timescale 1ns / 1ps
module nfbt_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  nfbt_req_if.sink             req,
  nfbt_rsp_if.source           rsp,
  output nfbt_pkg::ram_req_t   ram_req,
  input  nfbt_pkg::hdr_word_t  rd,
  output nfbt_pkg::step_req_t  step_req,
  input  nfbt_pkg::step_rsp_t  step_rsp,
  output nfbt_pkg::status_t    status
);

  localparam int GW = nfbt_pkg::GRAN_W;
  localparam int SH = nfbt_pkg::ALIGN_SH;

  nfbt_pkg::state_t state_r, state_nxt, pubret_r, pubret_nxt;
  nfbt_pkg::mode_t  mode_r, mode_nxt;

  logic [1:0]    typ_r, typ_nxt;
  logic          hasp_r, hasp_nxt;
  logic [15:0]   ptr_r, ptr_nxt;
  logic [15:0]   size_r, size_nxt;
  logic [GW:0]   need_r, need_nxt;
  logic [GW-1:0] g_r, g_nxt;
  logic [GW-1:0] start_r, start_nxt;
  logic          wrap_r, wrap_nxt;
  logic [GW-1:0] szg_r, szg_nxt;
  logic [GW-1:0] prv_r, prv_nxt;
  logic [GW-1:0] nxt_r, nxt_nxt;
  logic          nxtok_r, nxtok_nxt;
  logic [GW-1:0] p_r, p_nxt;
  logic          markg_r, markg_nxt;
  logic          mrgany_r, mrgany_nxt;
  logic          mrgp_r, mrgp_nxt;
  logic [GW-1:0] pubv_r, pubv_nxt;
  logic [GW-1:0] puba_r, puba_nxt;
  logic [15:0]   oldb_r, oldb_nxt;
  logic [15:0]   rover_r, rover_nxt;
  logic [16:0]   used_r, used_nxt;
  logic [16:0]   peak_r, peak_nxt;
  logic          open_r, open_nxt;
  logic [GW-1:0] clr_r, clr_nxt;
  logic          reinit_r, reinit_nxt;
  logic          rp_r, rp_nxt;
  logic [15:0]   ro_r, ro_nxt;
  logic          mv_r, mv_nxt;
  logic [15:0]   cs_r, cs_nxt;
  logic [15:0]   cl_r, cl_nxt;

  // decode of the given pointer
  logic          ptr_ok;
  logic [GW-1:0] gp;
  assign ptr_ok = (ptr_r >= 16'(nfbt_pkg::HDR_G * nfbt_pkg::ALIGN_BYTES)) &&
                  (ptr_r[SH-1:0] == '0);
  assign gp = GW'(ptr_r >> SH) - GW'(nfbt_pkg::HDR_G);

  // header tests on the word just read
  logic          hit_used, hit_free, fits, rest_ok, miss_fail, prev_ok;
  logic [GW-1:0] rest, p_comb;
  logic [16:0]   blk_bytes;
  assign hit_used  = rd.mark && !rd.free;
  assign hit_free  = rd.mark && rd.free;
  assign fits      = ({1'b0, rd.size} >= need_r);
  assign rest      = rd.size - need_r[GW-1:0];
  assign rest_ok   = (rest >= GW'(nfbt_pkg::HDR_G + 1));
  assign miss_fail = wrap_r || (start_r == '0);
  assign prev_ok   = (g_r != '0) && (prv_r != '0) &&
                     ({1'b0, g_r} >= ({1'b0, prv_r} + (GW+1)'(nfbt_pkg::HDR_G)));
  assign p_comb    = g_r - prv_r - GW'(nfbt_pkg::HDR_G);
  assign blk_bytes = 17'(rd.size) << SH;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfbt_pkg::ST_CLEAR: begin
        if (clr_r == GW'(nfbt_pkg::GRAN_COUNT - 1)) begin
          state_nxt = reinit_r ? nfbt_pkg::ST_OUT : nfbt_pkg::ST_IDLE;
        end
      end
      nfbt_pkg::ST_IDLE: begin
        if (req.valid) state_nxt = nfbt_pkg::ST_DISPATCH;
      end
      nfbt_pkg::ST_DISPATCH: begin
        state_nxt = nfbt_pkg::ST_OUT;
        case (typ_r)
          nfbt_pkg::REQ_REINIT: state_nxt = nfbt_pkg::ST_CLEAR;
          nfbt_pkg::REQ_REALLOC: begin
            if (open_r) begin
              if (size_r == '0) begin
                if (hasp_r && ptr_ok) state_nxt = nfbt_pkg::ST_FND_RD;
              end else if (!hasp_r) begin
                state_nxt = nfbt_pkg::ST_AL_INIT;
              end else if (ptr_ok) begin
                state_nxt = nfbt_pkg::ST_FND_RD;
              end
            end
          end
          default: state_nxt = nfbt_pkg::ST_OUT;
        endcase
      end
      nfbt_pkg::ST_FND_RD: state_nxt = nfbt_pkg::ST_FND_CHK;
      nfbt_pkg::ST_FND_CHK: begin
        if (!hit_used) begin
          state_nxt = nfbt_pkg::ST_OUT;
        end else if (mode_r == nfbt_pkg::MODE_FREE) begin
          state_nxt = step_rsp.in_range ? nfbt_pkg::ST_MN_RD : nfbt_pkg::ST_MP;
        end else begin
          state_nxt = fits ? nfbt_pkg::ST_OUT : nfbt_pkg::ST_AL_INIT;
        end
      end
      nfbt_pkg::ST_MN_RD:  state_nxt = nfbt_pkg::ST_MN_CHK;
      nfbt_pkg::ST_MN_CHK: state_nxt = nfbt_pkg::ST_MP;
      nfbt_pkg::ST_MP: begin
        state_nxt = prev_ok ? nfbt_pkg::ST_MP_CHK : nfbt_pkg::ST_MG_WR;
      end
      nfbt_pkg::ST_MP_CHK: state_nxt = nfbt_pkg::ST_MG_WR;
      nfbt_pkg::ST_MG_WR: begin
        state_nxt = (mrgany_r && step_rsp.in_range) ? nfbt_pkg::ST_PB_RD : nfbt_pkg::ST_OUT;
      end
      nfbt_pkg::ST_PB_RD:   state_nxt = nfbt_pkg::ST_PB_CHK;
      nfbt_pkg::ST_PB_CHK:  state_nxt = pubret_r;
      nfbt_pkg::ST_AL_INIT: state_nxt = nfbt_pkg::ST_AL_RD;
      nfbt_pkg::ST_AL_RD:   state_nxt = nfbt_pkg::ST_AL_CHK;
      nfbt_pkg::ST_AL_CHK: begin
        if (!rd.mark || (!(hit_free && fits) && !step_rsp.in_range)) begin
          state_nxt = miss_fail ? nfbt_pkg::ST_OUT : nfbt_pkg::ST_AL_RD;
        end else if (hit_free && fits) begin
          state_nxt = rest_ok ? nfbt_pkg::ST_SP_WR : nfbt_pkg::ST_AL_WRG;
        end else if (wrap_r && (step_rsp.sum[GW-1:0] > start_r)) begin
          state_nxt = nfbt_pkg::ST_OUT;
        end else begin
          state_nxt = nfbt_pkg::ST_AL_RD;
        end
      end
      nfbt_pkg::ST_SP_WR: begin
        state_nxt = (step_rsp.in_range && nxtok_r) ? nfbt_pkg::ST_PB_RD
                                                    : nfbt_pkg::ST_AL_WRG;
      end
      nfbt_pkg::ST_AL_WRG: begin
        state_nxt = (mode_r == nfbt_pkg::MODE_REALLOC) ? nfbt_pkg::ST_FND_RD
                                                       : nfbt_pkg::ST_OUT;
      end
      nfbt_pkg::ST_OUT: begin
        if (rsp.ready) state_nxt = nfbt_pkg::ST_IDLE;
      end
      default: state_nxt = nfbt_pkg::ST_IDLE;
    endcase
  end

  // memory and step-unit controls
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = g_r;
    ram_req.wdata = '0;
    ram_req.raddr = g_r;
    step_req.base = g_r;
    step_req.len  = {1'b0, szg_r};
    case (state_r)
      nfbt_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_r;
        if (clr_r == '0) begin
          ram_req.wdata = '{mark: 1'b1, free: 1'b1,
                            size: GW'(nfbt_pkg::GRAN_COUNT - nfbt_pkg::HDR_G),
                            prev: '0};
        end
      end
      nfbt_pkg::ST_FND_RD:  ram_req.raddr = gp;
      nfbt_pkg::ST_FND_CHK: step_req.len = {1'b0, rd.size};
      nfbt_pkg::ST_MN_RD:   ram_req.raddr = nxt_r;
      nfbt_pkg::ST_MN_CHK: begin
        // absorbed successor loses its start mark
        if (hit_free) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = nxt_r;
          ram_req.wdata = '{mark: 1'b0, free: rd.free, size: rd.size, prev: rd.prev};
        end
      end
      nfbt_pkg::ST_MP: ram_req.raddr = p_comb;
      nfbt_pkg::ST_MP_CHK: begin
        if (hit_free) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = p_r;
          ram_req.wdata = '{mark: 1'b1, free: 1'b1,
                            size: rd.size + GW'(nfbt_pkg::HDR_G) + szg_r,
                            prev: rd.prev};
        end
      end
      nfbt_pkg::ST_MG_WR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '{mark: markg_r, free: 1'b1, size: szg_r, prev: prv_r};
      end
      nfbt_pkg::ST_PB_RD: ram_req.raddr = puba_r;
      nfbt_pkg::ST_PB_CHK: begin
        if (rd.mark) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = puba_r;
          ram_req.wdata = '{mark: 1'b1, free: rd.free, size: rd.size, prev: pubv_r};
        end
      end
      nfbt_pkg::ST_AL_CHK: step_req.len = {1'b0, rd.size};
      nfbt_pkg::ST_SP_WR: begin
        // tail of the chosen block becomes a free block
        step_req.len = need_r;
        if (step_rsp.in_range) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = step_rsp.sum[GW-1:0];
          ram_req.wdata = '{mark: 1'b1, free: 1'b1,
                            size: szg_r - need_r[GW-1:0] - GW'(nfbt_pkg::HDR_G),
                            prev: need_r[GW-1:0]};
        end
      end
      nfbt_pkg::ST_AL_WRG: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '{mark: 1'b1, free: 1'b0, size: szg_r, prev: prv_r};
      end
      default: ;
    endcase
  end

  // datapath register updates
  always_comb begin
    logic [16:0] used_add;
    logic [GW-1:0] msz;
    typ_nxt = typ_r;   hasp_nxt = hasp_r; ptr_nxt = ptr_r;   size_nxt = size_r;
    need_nxt = need_r; mode_nxt = mode_r; g_nxt = g_r;       start_nxt = start_r;
    wrap_nxt = wrap_r; szg_nxt = szg_r;   prv_nxt = prv_r;   nxt_nxt = nxt_r;
    nxtok_nxt = nxtok_r; p_nxt = p_r;     markg_nxt = markg_r;
    mrgany_nxt = mrgany_r; mrgp_nxt = mrgp_r; pubv_nxt = pubv_r; puba_nxt = puba_r;
    pubret_nxt = pubret_r; oldb_nxt = oldb_r; rover_nxt = rover_r;
    used_nxt = used_r; peak_nxt = peak_r; open_nxt = open_r;
    clr_nxt = clr_r;   reinit_nxt = reinit_r;
    rp_nxt = rp_r; ro_nxt = ro_r; mv_nxt = mv_r; cs_nxt = cs_r; cl_nxt = cl_r;
    used_add = used_r + (17'(szg_r) << SH);
    msz = szg_r + GW'(nfbt_pkg::HDR_G) + rd.size;
    case (state_r)
      nfbt_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == GW'(nfbt_pkg::GRAN_COUNT - 1)) reinit_nxt = 1'b0;
      end
      nfbt_pkg::ST_IDLE: begin
        if (req.valid) begin
          typ_nxt  = req.req_type;
          hasp_nxt = req.pointer_present;
          ptr_nxt  = req.pointer_offset;
          size_nxt = req.request_size;
          need_nxt = (GW+1)'((17'(req.request_size) + 17'(nfbt_pkg::ALIGN_BYTES - 1)) >> SH);
        end
      end
      nfbt_pkg::ST_DISPATCH: begin
        rp_nxt = 1'b0; ro_nxt = '0; mv_nxt = 1'b0; cs_nxt = '0; cl_nxt = '0;
        case (typ_r)
          nfbt_pkg::REQ_REINIT: begin
            used_nxt = '0; peak_nxt = '0; rover_nxt = '0; open_nxt = 1'b1;
            reinit_nxt = 1'b1; clr_nxt = '0;
          end
          nfbt_pkg::REQ_CLOSE: begin
            open_nxt = 1'b0; used_nxt = '0; rover_nxt = '0;
          end
          nfbt_pkg::REQ_REALLOC: begin
            if (size_r == '0)  mode_nxt = nfbt_pkg::MODE_FREE;
            else if (!hasp_r)  mode_nxt = nfbt_pkg::MODE_ALLOC;
            else               mode_nxt = nfbt_pkg::MODE_REALLOC;
          end
          default: ;
        endcase
      end
      nfbt_pkg::ST_FND_RD: g_nxt = gp;
      nfbt_pkg::ST_FND_CHK: begin
        szg_nxt = rd.size; prv_nxt = rd.prev; markg_nxt = 1'b1;
        mrgany_nxt = 1'b0; mrgp_nxt = 1'b0;
        nxt_nxt = step_rsp.sum[GW-1:0];
        if (hit_used) begin
          if (mode_r == nfbt_pkg::MODE_FREE) begin
            used_nxt = (used_r < blk_bytes) ? '0 : used_r - blk_bytes;
          end else if (fits) begin
            rp_nxt = 1'b1; ro_nxt = ptr_r;
          end else begin
            oldb_nxt = 16'(blk_bytes);
          end
        end
      end
      nfbt_pkg::ST_MN_CHK: begin
        if (hit_free) begin
          szg_nxt = msz; pubv_nxt = msz; mrgany_nxt = 1'b1;
        end
      end
      nfbt_pkg::ST_MP: p_nxt = p_comb;
      nfbt_pkg::ST_MP_CHK: begin
        if (hit_free) begin
          markg_nxt = 1'b0; mrgp_nxt = 1'b1; mrgany_nxt = 1'b1; pubv_nxt = msz;
        end
      end
      nfbt_pkg::ST_MG_WR: begin
        rover_nxt  = 16'(mrgp_r ? p_r : g_r) << SH;
        puba_nxt   = step_rsp.sum[GW-1:0];
        pubret_nxt = nfbt_pkg::ST_OUT;
      end
      nfbt_pkg::ST_AL_INIT: begin
        start_nxt = GW'(rover_r >> SH);
        g_nxt     = GW'(rover_r >> SH);
        wrap_nxt  = 1'b0;
      end
      nfbt_pkg::ST_AL_CHK: begin
        nxt_nxt   = step_rsp.sum[GW-1:0];
        nxtok_nxt = step_rsp.in_range;
        if (!rd.mark || (!(hit_free && fits) && !step_rsp.in_range)) begin
          if (!miss_fail) begin
            wrap_nxt = 1'b1; g_nxt = '0;
          end
        end else if (hit_free && fits) begin
          szg_nxt = rd.size; prv_nxt = rd.prev;
        end else begin
          g_nxt = step_rsp.sum[GW-1:0];
        end
      end
      nfbt_pkg::ST_SP_WR: begin
        if (step_rsp.in_range) begin
          szg_nxt    = need_r[GW-1:0];
          pubv_nxt   = szg_r - need_r[GW-1:0] - GW'(nfbt_pkg::HDR_G);
          puba_nxt   = nxt_r;
          pubret_nxt = nfbt_pkg::ST_AL_WRG;
        end
      end
      nfbt_pkg::ST_AL_WRG: begin
        used_nxt  = used_add;
        if (used_add > peak_r) peak_nxt = used_add;
        rover_nxt = step_rsp.in_range ? (16'(step_rsp.sum[GW-1:0]) << SH) : '0;
        rp_nxt    = 1'b1;
        ro_nxt    = 16'(g_r + GW'(nfbt_pkg::HDR_G)) << SH;
        if (mode_r == nfbt_pkg::MODE_REALLOC) begin
          mv_nxt   = 1'b1;
          cs_nxt   = ptr_r;
          cl_nxt   = (oldb_r < size_r) ? oldb_r : size_r;
          mode_nxt = nfbt_pkg::MODE_FREE;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nfbt_pkg::ST_CLEAR;
      clr_r    <= '0;
      reinit_r <= 1'b0;
      rover_r  <= '0;
      used_r   <= '0;
      peak_r   <= '0;
      open_r   <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      reinit_r <= reinit_nxt;
      rover_r  <= rover_nxt;
      used_r   <= used_nxt;
      peak_r   <= peak_nxt;
      open_r   <= open_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    typ_r <= typ_nxt;   hasp_r <= hasp_nxt; ptr_r <= ptr_nxt;   size_r <= size_nxt;
    need_r <= need_nxt; mode_r <= mode_nxt; g_r <= g_nxt;       start_r <= start_nxt;
    wrap_r <= wrap_nxt; szg_r <= szg_nxt;   prv_r <= prv_nxt;   nxt_r <= nxt_nxt;
    nxtok_r <= nxtok_nxt; p_r <= p_nxt;     markg_r <= markg_nxt;
    mrgany_r <= mrgany_nxt; mrgp_r <= mrgp_nxt; pubv_r <= pubv_nxt; puba_r <= puba_nxt;
    pubret_r <= pubret_nxt; oldb_r <= oldb_nxt;
    rp_r <= rp_nxt; ro_r <= ro_nxt; mv_r <= mv_nxt; cs_r <= cs_nxt; cl_r <= cl_nxt;
  end

  // channel outputs
  assign req.ready          = (state_r == nfbt_pkg::ST_IDLE);
  assign rsp.valid          = (state_r == nfbt_pkg::ST_OUT);
  assign rsp.result_present = rp_r;
  assign rsp.result_offset  = ro_r;
  assign rsp.moved          = mv_r;
  assign rsp.copy_source    = cs_r;
  assign rsp.copy_length    = cl_r;
  assign rsp.used_bytes     = used_r;
  assign rsp.peak_used      = peak_r;

  assign status.clearing = (state_r == nfbt_pkg::ST_CLEAR);
  assign status.scanning = (state_r == nfbt_pkg::ST_AL_RD) || (state_r == nfbt_pkg::ST_AL_CHK);

endmodule
